@@ src/wss_pkg.sv @@
// ----------------------------------------------------------------------------
// wss_pkg: shared types and constants of the weighted spread sequencer
// Sizes, state encoding and the buses between controller and slot store.
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int WEIGHT_BITS  = 16;

  // field widths fixed by the interface
  localparam int WGT_IN_W = 16;
  localparam int ELEM_W   = 5;
  localparam int TOT_W    = 20;

  localparam int W_W    = (WEIGHT_BITS < WGT_IN_W) ? WEIGHT_BITS : WGT_IN_W;
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int ID_W   = CNT_W;
  localparam int PROD_W = 2 * TOT_W;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_REQ  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP,
    ST_FETCH,
    ST_CMP,
    ST_PARK,
    ST_DONE
  } wss_state_t;

  typedef struct packed {
    logic              rw_we;
    logic [ADDR_W-1:0] rw_addr;
    logic [W_W-1:0]    rw_data;
    logic              pt_we;
    logic [ADDR_W-1:0] pt_addr;
    logic [TOT_W-1:0]  pt_data;
    logic              id_we;
    logic [ADDR_W-1:0] id_addr;
    logic [ID_W-1:0]   id_data;
  } wss_wr_t;

  typedef struct packed {
    logic [W_W-1:0]   w;
    logic [TOT_W-1:0] pt;
    logic [ID_W-1:0]  id;
  } wss_rd_t;

endpackage

@@ src/weighted_spread_sequencer.sv @@
// ----------------------------------------------------------------------------
// weighted_spread_sequencer: weighted element sequence generator
// Loads append weighted slots; each request yields the next element id.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): in_operation selects load (weight
//   appended as a new slot, ids from 1) or request. A load gives no result
//   and leaves the block idle, ready for a further transfer. Loads
//   beyond the slot capacity are dropped.
//   Result channel (out_valid / out_stall): one out_element per request,
//   0 once all loaded weight has been served.
//   Occupancy: a request holds the block through ST_TOP, one ST_FETCH/ST_CMP
//   pair per walk step, ST_PARK when the walk reaches the bottom slot, and
//   ST_DONE until the result register frees; at most N-1 downward swaps,
//   no walk with one slot loaded. Each walk step is one slot-store read plus
//   one pass through the shared multiply/compare unit; a failing compare or
//   the park state ends it. A request with nothing left to serve goes to
//   ST_DONE directly. The result is valid at the edge ending the occupancy.
//   Receiver stall: the result register holds; loads are still taken, and a
//   further request finishes its walk and waits until the register frees.
//   Reset (rst_n low, synchronous): empties all slots, clears the totals and
//   run counter, restores ids to slot index plus one, drops any result.
// ----------------------------------------------------------------------------
module weighted_spread_sequencer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic [wss_pkg::WGT_IN_W-1:0] in_weight,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [wss_pkg::ELEM_W-1:0]   out_element
);
  import wss_pkg::*;

  // slot store interface
  logic [ADDR_W-1:0] rd_addr;
  wss_wr_t           wr;
  wss_rd_t           rd;

  // walk unit interface
  logic [TOT_W-1:0]  run_cnt;
  logic [W_W-1:0]    mov_w;
  logic              swap_ok;

  wss_slot_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  // compares the moving slot's weight with run counter x prefix sum below
  wss_walk_unit u_walk (
    .clk      (clk),
    .run_cnt  (run_cnt),
    .lower_pt (rd.pt),
    .mov_w    (mov_w),
    .swap_ok  (swap_ok)
  );

  wss_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_weight    (in_weight),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_element  (out_element),
    .out_stall    (out_stall),
    .rd           (rd),
    .swap_ok      (swap_ok),
    .rd_addr      (rd_addr),
    .wr           (wr),
    .run_cnt      (run_cnt),
    .mov_w        (mov_w)
  );

endmodule

@@ src/wss_slot_mem.sv @@
// ----------------------------------------------------------------------------
// wss_slot_mem: per-slot weight, prefix sum and id store
// One registered read port, one write port per array; ids default to index+1.
// ----------------------------------------------------------------------------
module wss_slot_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [wss_pkg::ADDR_W-1:0] rd_addr,
  input  wss_pkg::wss_wr_t           wr,
  output wss_pkg::wss_rd_t           rd
);
  import wss_pkg::*;

  logic [W_W-1:0]          rw_mem_r [MAX_ELEMENTS];
  logic [TOT_W-1:0]        pt_mem_r [MAX_ELEMENTS];
  logic [ID_W-1:0]         id_mem_r [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] id_vld_r;
  wss_rd_t                 rd_r;

  always_ff @(posedge clk) begin
    if (wr.rw_we) rw_mem_r[wr.rw_addr] <= wr.rw_data;
    if (wr.pt_we) pt_mem_r[wr.pt_addr] <= wr.pt_data;
    if (wr.id_we) id_mem_r[wr.id_addr] <= wr.id_data;
    rd_r.w  <= rw_mem_r[rd_addr];
    rd_r.pt <= pt_mem_r[rd_addr];
    // untouched slot still carries its reset id
    rd_r.id <= id_vld_r[rd_addr] ? id_mem_r[rd_addr] : ID_W'(rd_addr) + ID_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_vld_r <= '0;
    end else if (wr.id_we) begin
      id_vld_r[wr.id_addr] <= 1'b1;
    end
  end

  assign rd = rd_r;

endmodule

@@ src/wss_walk_unit.sv @@
// ----------------------------------------------------------------------------
// wss_walk_unit: shared multiply and compare for the swap walk
// Registers run counter x lower prefix sum, then tests weight <= product.
// ----------------------------------------------------------------------------
module wss_walk_unit (
  input  logic                      clk,
  input  logic [wss_pkg::TOT_W-1:0] run_cnt,
  input  logic [wss_pkg::TOT_W-1:0] lower_pt,
  input  logic [wss_pkg::W_W-1:0]   mov_w,
  output logic                      swap_ok
);
  import wss_pkg::*;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(run_cnt) * PROD_W'(lower_pt);
  end

  assign swap_ok = (PROD_W'(mov_w) <= prod_r);

endmodule

@@ src/wss_ctrl.sv @@
// ----------------------------------------------------------------------------
// wss_ctrl: sequencer of the weighted spread sequencer
// Handles loads, walks the requested slot downwards, drives the result.
// ----------------------------------------------------------------------------
module wss_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_operation,
  input  logic [wss_pkg::WGT_IN_W-1:0] in_weight,
  output logic                         in_stall,
  output logic                         out_valid,
  output logic [wss_pkg::ELEM_W-1:0]   out_element,
  input  logic                         out_stall,
  input  wss_pkg::wss_rd_t             rd,
  input  logic                         swap_ok,
  output logic [wss_pkg::ADDR_W-1:0]   rd_addr,
  output wss_pkg::wss_wr_t             wr,
  output logic [wss_pkg::TOT_W-1:0]    run_cnt,
  output logic [wss_pkg::W_W-1:0]      mov_w
);
  import wss_pkg::*;

  wss_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  loaded_r, loaded_nxt;
  logic [TOT_W-1:0]  gt_r, gt_nxt;
  logic [TOT_W-1:0]  served_r, served_nxt;
  logic [TOT_W-1:0]  rc_r, rc_nxt;
  logic [ADDR_W-1:0] top_r, top_nxt;
  logic [W_W-1:0]    mov_w_r, mov_w_nxt;
  logic [ID_W-1:0]   mov_id_r, mov_id_nxt;
  logic [ID_W-1:0]   ret_r, ret_nxt;
  logic              swapped_r, swapped_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0] out_element_r, out_element_nxt;

  logic              in_acc;
  logic              req_live;
  logic              out_free;
  logic [W_W-1:0]    load_w;
  logic [TOT_W-1:0]  load_sum;
  logic              top_zero;

  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign req_live = (loaded_r != '0) && (served_r < gt_r);
  assign out_free = !out_valid_r || !out_stall;
  assign load_w   = in_weight[W_W-1:0];
  assign load_sum = gt_r + TOT_W'(load_w);
  assign top_zero = (rd.w == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_operation == OP_REQ)) state_nxt = req_live ? ST_TOP : ST_DONE;
      end
      ST_TOP:   state_nxt = (top_r == '0) ? ST_DONE : ST_FETCH;
      ST_FETCH: state_nxt = ST_CMP;
      ST_CMP: begin
        if (swap_ok) state_nxt = (top_r == ADDR_W'(1)) ? ST_PARK : ST_FETCH;
        else         state_nxt = ST_DONE;
      end
      ST_PARK: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath controls and register updates
  always_comb begin
    loaded_nxt      = loaded_r;
    gt_nxt          = gt_r;
    served_nxt      = served_r;
    rc_nxt          = rc_r;
    top_nxt         = top_r;
    mov_w_nxt       = mov_w_r;
    mov_id_nxt      = mov_id_r;
    ret_nxt         = ret_r;
    swapped_nxt     = swapped_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_element_nxt = out_element_r;
    wr              = '0;
    rd_addr         = top_r - ADDR_W'(1);
    case (state_r)
      ST_IDLE: begin
        rd_addr = ADDR_W'(loaded_r - CNT_W'(1));
        if (in_acc) begin
          if (in_operation == OP_LOAD) begin
            if (loaded_r < CNT_W'(MAX_ELEMENTS)) begin
              gt_nxt     = load_sum;
              wr.rw_we   = 1'b1;
              wr.rw_addr = ADDR_W'(loaded_r);
              wr.rw_data = load_w;
              wr.pt_we   = 1'b1;
              wr.pt_addr = ADDR_W'(loaded_r);
              wr.pt_data = load_sum;
              loaded_nxt = loaded_r + CNT_W'(1);
            end
          end else begin
            swapped_nxt = 1'b0;
            if (req_live) begin
              top_nxt    = ADDR_W'(loaded_r - CNT_W'(1));
              served_nxt = served_r + TOT_W'(1);
              rc_nxt     = rc_r + TOT_W'(1);
            end else begin
              ret_nxt = '0;
            end
          end
        end
      end
      ST_TOP: begin
        // spend one unit of the top slot, saturating at zero
        wr.rw_we   = 1'b1;
        wr.rw_addr = top_r;
        wr.rw_data = top_zero ? rd.w : rd.w - W_W'(1);
        wr.pt_we   = 1'b1;
        wr.pt_addr = top_r;
        wr.pt_data = top_zero ? rd.pt : rd.pt - TOT_W'(1);
        mov_w_nxt  = top_zero ? rd.w : rd.w - W_W'(1);
        mov_id_nxt = rd.id;
        ret_nxt    = rd.id;
      end
      ST_FETCH: begin
        rd_addr = top_r - ADDR_W'(1);
      end
      ST_CMP: begin
        if (swap_ok) begin
          // lower slot moves up; moving slot stays in registers
          wr.rw_we    = 1'b1;
          wr.rw_addr  = top_r;
          wr.rw_data  = rd.w;
          wr.id_we    = 1'b1;
          wr.id_addr  = top_r;
          wr.id_data  = rd.id;
          wr.pt_we    = 1'b1;
          wr.pt_addr  = top_r - ADDR_W'(1);
          wr.pt_data  = rd.pt + TOT_W'(mov_w_r) - TOT_W'(rd.w);
          top_nxt     = top_r - ADDR_W'(1);
          swapped_nxt = 1'b1;
          rd_addr     = top_r - ADDR_W'(2);
        end else begin
          wr.rw_we   = 1'b1;
          wr.rw_addr = top_r;
          wr.rw_data = mov_w_r;
          wr.id_we   = 1'b1;
          wr.id_addr = top_r;
          wr.id_data = mov_id_r;
        end
      end
      ST_PARK: begin
        wr.rw_we   = 1'b1;
        wr.rw_addr = top_r;
        wr.rw_data = mov_w_r;
        wr.id_we   = 1'b1;
        wr.id_addr = top_r;
        wr.id_data = mov_id_r;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_element_nxt = ELEM_W'(ret_r);
          if (swapped_r) rc_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      gt_r        <= '0;
      served_r    <= '0;
      rc_r        <= '0;
      swapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      gt_r        <= gt_nxt;
      served_r    <= served_nxt;
      rc_r        <= rc_nxt;
      swapped_r   <= swapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r         <= top_nxt;
    mov_w_r       <= mov_w_nxt;
    mov_id_r      <= mov_id_nxt;
    ret_r         <= ret_nxt;
    out_element_r <= out_element_nxt;
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_element = out_element_r;
  assign run_cnt     = rc_r;
  assign mov_w       = mov_w_r;

endmodule

@@ src/wss_checker.sv @@
// ----------------------------------------------------------------------------
// wss_checker: port-level checks of the weighted spread sequencer
// Reset state, load/request occupancy and result hold under stall.
// ----------------------------------------------------------------------------
module wss_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_operation,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [wss_pkg::ELEM_W-1:0] out_element
);
  import wss_pkg::*;

  // idle and empty straight after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !in_stall && !out_valid)
    else $error("not idle after reset");

  // a load transfer leaves the block ready
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == OP_LOAD) |=> !in_stall)
    else $error("load held the input");

  // a request transfer always occupies the block
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == OP_REQ) |=> in_stall)
    else $error("request did not occupy the block");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_element))
    else $error("result changed under stall");

endmodule

bind weighted_spread_sequencer wss_checker u_wss_checker (.*);
